FILE: rtl/fes_pkg.sv
// Shared definitions for the fire effect stencil: frame geometry, line store
// sizing, configuration register indexes and the beat types of both streams.
// Has no dependencies.
package fes_pkg;

  localparam int WIDTH      = 640;
  localparam int HEIGHT     = 480;
  localparam int LINE_LEN   = WIDTH + 2;
  localparam int ROWS_TOTAL = HEIGHT + 2;
  localparam int POS_W      = 12;
  localparam int RAM_DEPTH  = 2 * LINE_LEN;
  localparam int RAM_ADDR_W = $clog2(RAM_DEPTH);

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_DECAY    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOW_CUT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HIGH_CUT = 2'd2;

  localparam logic [7:0] DECAY_RESET    = 8'd7;
  localparam logic [7:0] LOW_CUT_RESET  = 8'd20;
  localparam logic [7:0] HIGH_CUT_RESET = 8'd230;

  typedef struct packed {
    logic [7:0] heat_in;
    logic       frame_start;
  } in_t;

  typedef struct packed {
    logic [POS_W-1:0] col;
    logic [POS_W-1:0] row;
    logic [7:0]       heat_out;
    logic             draw;
    logic [15:0]      colour;
  } out_t;

endpackage

FILE: rtl/fes_ram.sv
// Generic RAM with one write port and two read ports sharing a read enable.
// Read data is registered and returns the old contents on a same-address write.
// Has no dependencies.
module fes_ram #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [DATA_W-1:0]        wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [DATA_W-1:0]        rdata_a,
  output logic [DATA_W-1:0]        rdata_b
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

endmodule

FILE: rtl/fire_effect_stencil.sv
// Top level of the fire effect stencil: position counters, the two-line store,
// and a three-stage pipeline for averaging, decay, cuts and palette lookup.
// Depends on fes_pkg and fes_ram.
//
//   channel  direction  handshake              beat
//   in       input      in_valid / in_ready    fes_pkg::in_t  (heat_in, frame_start)
//   out      output     out_valid / out_ready  fes_pkg::out_t (col, row, heat_out, draw, colour)
//   cfg      input      cfg_valid / cfg_ready  cfg_index, cfg_data (8 bits)
//
// One input beat per cycle is sustained while out_ready stays high; a result passes the
// registered reads of the line store and two math stages before it leaves.
// Reset clears counters, stage valid bits and the configuration registers; the line store is
// not cleared, every read that feeds a result hits an entry written earlier in the same frame.
// Each stage holds under a stall and empty stages still fill, so no beat is lost.
module fire_effect_stencil (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  fes_pkg::in_t                     in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output fes_pkg::out_t                    out_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [fes_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [7:0]                       cfg_data
);

  localparam int AW = fes_pkg::RAM_ADDR_W;
  localparam int PW = fes_pkg::POS_W;
  localparam logic [PW-1:0] LAST_COL  = PW'(fes_pkg::LINE_LEN - 1);
  localparam logic [PW-1:0] MAX_COL   = PW'(fes_pkg::WIDTH);
  localparam logic [PW-1:0] ROW_LIMIT = PW'(fes_pkg::ROWS_TOTAL);
  localparam logic [AW-1:0] HALF_BASE = AW'(fes_pkg::LINE_LEN);

  function automatic logic [15:0] fire_colour(input logic [7:0] h);
    logic [7:0] r;
    logic [7:0] g;
    logic [8:0] b;
    r = 8'd255;
    g = 8'd0;
    b = 9'd0;
    if (h == 8'd0) begin
      b = 9'd255;
    end else if (h < 8'd64) begin
      r = {h[6:0], 1'b0};
    end else if (h < 8'd128) begin
      g = {h[5:0], 2'b00};
    end else begin
      g = 8'd252;
      b = {h[6:1], 3'b000};
      if (b > 9'd255) begin
        b = 9'd255;
      end
    end
    return {r[7:3], g[7:2], b[7:3]};
  endfunction

  logic [7:0] decay;
  logic [7:0] low_cut;
  logic [7:0] high_cut;

  logic [PW-1:0] col_count;
  logic [PW-1:0] row_count;
  logic [7:0]    first_cur;
  logic [7:0]    first_prev;

  logic          v1;
  logic [7:0]    s1_heat;
  logic [PW-1:0] s1_col;
  logic [PW-1:0] s1_row;
  logic          s1_produce;
  logic [7:0]    s1_first;

  logic          v2;
  logic [9:0]    s2_sum;
  logic [7:0]    s2_centre;
  logic [PW-1:0] s2_col;
  logic [PW-1:0] s2_row;
  logic          s2_produce;

  logic [7:0]    tap_c;
  logic [7:0]    tap_l;

  logic          v3;
  fes_pkg::out_t s3;

  logic en1;
  logic en2;
  logic en3;
  logic accept;

  logic [PW-1:0] c0;
  logic [PW-1:0] r0;
  logic          active;
  logic          produce0;
  logic [AW-1:0] cur_base;
  logic [AW-1:0] prev_base;
  logic [AW-1:0] addr_cur;
  logic [AW-1:0] addr_right;
  logic [PW-1:0] col_next;
  logic [PW-1:0] row_next;

  logic [7:0] ram_above;
  logic [7:0] ram_right;
  logic [7:0] left1;
  logic [9:0] sum1;

  logic [8:0] diff;
  logic       kept;

  assign en3       = !v3 || out_ready;
  assign en2       = !v2 || en3;
  assign en1       = !v1 || en2;
  assign in_ready  = en1;
  assign accept    = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  always_comb begin
    c0        = in_data.frame_start ? '0 : col_count;
    r0        = in_data.frame_start ? '0 : row_count;
    active    = r0 < ROW_LIMIT;
    produce0  = (r0 >= PW'(2)) && (c0 >= PW'(1)) && (c0 <= MAX_COL);
    cur_base  = r0[0] ? HALF_BASE : '0;
    prev_base = r0[0] ? '0 : HALF_BASE;
    addr_cur  = cur_base + AW'(c0);
    addr_right = prev_base + ((c0 == LAST_COL) ? AW'(c0) : AW'(c0 + PW'(1)));
    col_next  = c0;
    row_next  = r0;
    if (active) begin
      if (c0 == LAST_COL) begin
        col_next = '0;
        row_next = r0 + PW'(1);
      end else begin
        col_next = c0 + PW'(1);
      end
    end
  end

  fes_ram #(
    .DATA_W(8),
    .DEPTH (fes_pkg::RAM_DEPTH)
  ) u_line_store (
    .clk    (clk),
    .we     (accept && active),
    .waddr  (addr_cur),
    .wdata  (in_data.heat_in),
    .re     (en1),
    .raddr_a(addr_cur),
    .raddr_b(addr_right),
    .rdata_a(ram_above),
    .rdata_b(ram_right)
  );

  always_comb begin
    left1 = (s1_col == PW'(1)) ? s1_first : tap_l;
    sum1  = 10'(ram_above) + 10'(s1_heat) + 10'(left1) + 10'(ram_right);
    diff  = {1'b0, s2_sum[9:2]} - {1'b0, decay};
    kept  = !diff[8] && (diff[7:0] >= low_cut) && (diff[7:0] <= high_cut);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      decay     <= fes_pkg::DECAY_RESET;
      low_cut   <= fes_pkg::LOW_CUT_RESET;
      high_cut  <= fes_pkg::HIGH_CUT_RESET;
      col_count <= '0;
      row_count <= '0;
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          fes_pkg::CFG_DECAY:    decay    <= cfg_data;
          fes_pkg::CFG_LOW_CUT:  low_cut  <= cfg_data;
          fes_pkg::CFG_HIGH_CUT: high_cut <= cfg_data;
          default: ;
        endcase
      end
      if (accept) begin
        col_count <= col_next;
        row_count <= row_next;
      end
      if (en1) begin
        v1 <= accept && active;
      end
      if (en2) begin
        v2 <= v1;
      end
      if (en3) begin
        v3 <= v2 && s2_produce;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && active && (c0 == '0)) begin
      first_prev <= first_cur;
      first_cur  <= in_data.heat_in;
    end
    if (en1) begin
      s1_heat    <= in_data.heat_in;
      s1_col     <= c0;
      s1_row     <= r0 - PW'(1);
      s1_produce <= produce0;
      s1_first   <= (c0 == '0) ? first_cur : first_prev;
    end
    if (en2) begin
      s2_sum     <= sum1;
      s2_centre  <= tap_c;
      s2_col     <= s1_col;
      s2_row     <= s1_row;
      s2_produce <= s1_produce;
      if (v1) begin
        tap_c <= ram_right;
        tap_l <= tap_c;
      end
    end
    if (en3) begin
      s3.col      <= s2_col;
      s3.row      <= s2_row;
      s3.heat_out <= kept ? diff[7:0] : 8'd0;
      s3.draw     <= kept && (s2_col[0] ^ s2_row[0]);
      s3.colour   <= fire_colour(s2_centre);
    end
  end

  assign out_valid = v3;
  assign out_data  = s3;

endmodule

FILE: verif/tb_top.sv
// Testbench for the fire effect stencil: streams the first rows of a bordered heat frame,
// rewrites the decay and cut registers between phases and checks every result beat.
// Depends on fes_pkg and the fire_effect_stencil RTL.
`timescale 1ns / 1ps

module tb_top;

  localparam int PW = fes_pkg::POS_W;
  localparam logic [fes_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 40_000;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned ABORT_LEN = 12;
  localparam int unsigned STEADY_FROM = 700;
  localparam int unsigned STEADY_TO = 1200;
  localparam int unsigned PROBE_SPAN = 200;

  class fire_frame_tracker;
    logic [7:0] lines [fes_pkg::RAM_DEPTH];
    int unsigned col_pos;
    int unsigned row_pos;
    logic [7:0] decay_amt;
    logic [7:0] low_cut;
    logic [7:0] high_cut;
    fes_pkg::out_t awaited [$];
    int unsigned faults;

    function new();
      foreach (lines[i]) lines[i] = 8'd0;
      col_pos = 0;
      row_pos = 0;
      decay_amt = fes_pkg::DECAY_RESET;
      low_cut = fes_pkg::LOW_CUT_RESET;
      high_cut = fes_pkg::HIGH_CUT_RESET;
      faults = 0;
    endfunction

    function void set_reg(logic [fes_pkg::CFG_IDX_W-1:0] idx, logic [7:0] val);
      case (idx)
        fes_pkg::CFG_DECAY: decay_amt = val;
        fes_pkg::CFG_LOW_CUT: low_cut = val;
        fes_pkg::CFG_HIGH_CUT: high_cut = val;
        default: ;
      endcase
    endfunction

    function logic [15:0] palette_rgb565(logic [7:0] h);
      int unsigned hv, r, g, b;
      hv = h;
      if (hv == 0) begin
        r = 255; g = 0; b = 255;
      end else if (hv < 64) begin
        r = 2 * hv; g = 0; b = 0;
      end else if (hv < 128) begin
        r = 255; g = (hv - 64) * 4; b = 0;
      end else begin
        r = 255; g = 252; b = ((hv - 128) >> 1) * 8;
        if (b > 255) b = 255;
      end
      return 16'(((r >> 3) << 11) | ((g >> 2) << 5) | (b >> 3));
    endfunction

    function void take_pixel(fes_pkg::in_t beat);
      int unsigned c, r, cur, prv, mean;
      int diff;
      logic kept;
      fes_pkg::out_t res;
      if (beat.frame_start) begin
        col_pos = 0;
        row_pos = 0;
      end
      if (row_pos >= fes_pkg::ROWS_TOTAL) return;
      c = col_pos;
      r = row_pos;
      cur = (r % 2) * fes_pkg::LINE_LEN;
      prv = ((r + 1) % 2) * fes_pkg::LINE_LEN;
      if (r >= 2 && c >= 1 && c <= fes_pkg::WIDTH) begin
        mean = (int'(lines[cur + c]) + int'(beat.heat_in) + int'(lines[prv + c - 1])
                + int'(lines[prv + c + 1])) / 4;
        diff = int'(mean) - int'(decay_amt);
        kept = (diff >= int'(low_cut)) && (diff <= int'(high_cut));
        res.col = PW'(c);
        res.row = PW'(r - 1);
        res.heat_out = kept ? 8'(diff) : 8'd0;
        res.draw = kept && ((c + r - 1) % 2 == 1);
        res.colour = palette_rgb565(lines[prv + c]);
        awaited.push_back(res);
      end
      lines[cur + c] = beat.heat_in;
      c++;
      if (c >= fes_pkg::LINE_LEN) begin
        c = 0;
        r++;
      end
      col_pos = c;
      row_pos = r;
    endfunction

    function void match_pixel(fes_pkg::out_t got);
      fes_pkg::out_t want;
      if (awaited.size() == 0) begin
        $display({"%0t: mismatch expected no beat",
                  " got col=%0d row=%0d heat=%0d draw=%0b colour=%h"},
                 $time, got.col, got.row, got.heat_out, got.draw, got.colour);
        faults++;
        return;
      end
      want = awaited.pop_front();
      if (got !== want) begin
        $display({"%0t: mismatch expected col=%0d row=%0d heat=%0d draw=%0b colour=%h",
                  " got col=%0d row=%0d heat=%0d draw=%0b colour=%h"}, $time,
                 want.col, want.row, want.heat_out, want.draw, want.colour,
                 got.col, got.row, got.heat_out, got.draw, got.colour);
        faults++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  logic in_valid;
  logic in_ready;
  fes_pkg::in_t in_data;
  logic out_valid;
  logic out_ready;
  fes_pkg::out_t out_data;
  logic cfg_valid;
  logic cfg_ready;
  logic [fes_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [7:0] cfg_data;
  logic steady;
  int unsigned cycles;
  fire_frame_tracker board;

  fire_effect_stencil DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_ready <= steady || ($urandom_range(99, 0) >= 29);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) board.match_pixel(out_data);
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic logic [7:0] random_heat();
    if ($urandom_range(7, 0) == 0) return $urandom_range(1, 0) ? 8'd255 : 8'd0;
    return 8'($urandom_range(255, 0));
  endfunction

  function automatic logic [7:0] probe_heat(input int unsigned k);
    case (k % 14)
      0: return 8'd0;
      1: return 8'd255;
      2: return 8'd1;
      3: return 8'd63;
      4: return 8'd64;
      5: return 8'd127;
      6: return 8'd128;
      7: return 8'd191;
      8: return 8'd192;
      9: return 8'd193;
      10: return 8'd254;
      11: return 8'd100;
      12: return 8'd20;
      default: return 8'd230;
    endcase
  endfunction

  task automatic send_beat(input logic [7:0] heat, input logic start);
    fes_pkg::in_t beat;
    beat.heat_in = heat;
    beat.frame_start = start;
    while (!steady && $urandom_range(99, 0) < 29) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= beat;
    do @(posedge clk); while (!in_ready);
    board.take_pixel(beat);
    @(negedge clk);
  endtask

  task automatic wait_results_drained();
    in_valid <= 1'b0;
    while (board.awaited.size() != 0) @(posedge clk);
    @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [fes_pkg::CFG_IDX_W-1:0] idx, input logic [7:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    board.set_reg(idx, val);
    @(negedge clk);
  endtask

  task automatic load_cut_regs(input logic [7:0] dec, input logic [7:0] lo,
                               input logic [7:0] hi);
    write_reg(fes_pkg::CFG_HIGH_CUT, hi);
    write_reg(CFG_UNUSED, 8'($urandom));
    write_reg(fes_pkg::CFG_DECAY, dec);
    write_reg(fes_pkg::CFG_LOW_CUT, lo);
    cfg_valid <= 1'b0;
  endtask

  task automatic fill_two_rows();
    logic [7:0] heat;
    for (int unsigned i = 0; i < 2 * fes_pkg::LINE_LEN; i++) begin
      steady = (i >= STEADY_FROM) && (i < STEADY_TO);
      heat = random_heat();
      if (i >= fes_pkg::LINE_LEN && i < fes_pkg::LINE_LEN + PROBE_SPAN
          && $urandom_range(1, 0) == 1)
        heat = probe_heat(i);
      send_beat(heat, i == 0);
    end
    steady = 1'b0;
  endtask

  task automatic run_phase(input logic [7:0] dec, input logic [7:0] lo, input logic [7:0] hi,
                           input int unsigned beats, input logic no_idle);
    wait_results_drained();
    load_cut_regs(dec, lo, hi);
    steady = no_idle;
    for (int unsigned i = 0; i < beats; i++)
      send_beat(random_heat(), 1'b0);
    steady = 1'b0;
  endtask

  initial begin
    board = new();
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = fes_pkg::CFG_DECAY;
    cfg_data = 8'd0;
    steady = 1'b0;
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // A short frame that is cut off by a new frame start.
    for (int unsigned i = 0; i < ABORT_LEN; i++)
      send_beat(random_heat(), i == 0);
    fill_two_rows();

    run_phase(8'd7, 8'd20, 8'd230, 16, 1'b0);
    run_phase(8'd0, 8'd0, 8'd255, 16, 1'b0);
    run_phase(8'd255, 8'd0, 8'd255, 8, 1'b0);
    run_phase(8'd0, 8'd255, 8'd255, 8, 1'b0);
    run_phase(8'd0, 8'd0, 8'd0, 8, 1'b0);
    run_phase(8'd3, 8'd10, 8'd250, 48, 1'b1);
    repeat (3)
      run_phase(8'($urandom_range(40, 0)), 8'($urandom_range(60, 0)),
                8'($urandom_range(255, 150)), 16, 1'b0);
    run_phase(8'($urandom), 8'($urandom), 8'($urandom), 16, 1'b0);

    wait_results_drained();
    if (board.faults == 0 && board.awaited.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end
endmodule

FILE: sim.f
rtl/fes_pkg.sv
rtl/fes_ram.sv
rtl/fire_effect_stencil.sv
verif/tb_top.sv
